// ===== rtl/core/im2col_patch_extractor_unit_assert.svh =====
// Assertion macros used by the im2col controller.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef IM2COL_PATCH_EXTRACTOR_UNIT_ASSERT_SVH
`define IM2COL_PATCH_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define IM2COL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IM2COL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/im2col_pkg.sv =====
`default_nettype none

package im2col_pkg;

  // Input transaction
  typedef struct packed {
    logic        op;
    logic [3:0]  channel;
    logic [4:0]  pixel_row;
    logic [4:0]  pixel_col;
    logic [31:0] pixel_value;
    logic [2:0]  kernel_row;
    logic [2:0]  kernel_col;
    logic [5:0]  out_row;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  out_col;
    logic        last;
  } result_t;

  // Configuration register contents
  typedef struct packed {
    logic [5:0] image_height;
    logic [5:0] image_width;
    logic [4:0] channel_count;
    logic [2:0] kernel_height;
    logic [2:0] kernel_width;
    logic [1:0] pad_height;
    logic [1:0] pad_width;
  } cfg_t;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd4;
  localparam logic [2:0] REG_PAD_HEIGHT    = 3'd5;
  localparam logic [2:0] REG_PAD_WIDTH     = 3'd6;

  // Register reset values
  localparam cfg_t CFG_RESET = '{
    image_height:  6'd32,
    image_width:   6'd32,
    channel_count: 5'd1,
    kernel_height: 3'd3,
    kernel_width:  3'd3,
    pad_height:    2'd1,
    pad_width:     2'd1
  };

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RUN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic col_clear;
    logic wr_en;
    logic rd_en;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_write;
    logic write_ok;
    logic emit_ok;
    logic col_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/im2col_ram.sv =====
`default_nettype none

module im2col_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/im2col_cfg.sv =====
`default_nettype none

module im2col_cfg
  import im2col_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [2:0] reg_index;
  logic       wr_strobe;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_strobe = psel && penable && pwrite;

  // Register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_strobe) begin
      case (reg_index)
        REG_IMAGE_HEIGHT:  cfg.image_height  <= pwdata[5:0];
        REG_IMAGE_WIDTH:   cfg.image_width   <= pwdata[5:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[4:0];
        REG_KERNEL_HEIGHT: cfg.kernel_height <= pwdata[2:0];
        REG_KERNEL_WIDTH:  cfg.kernel_width  <= pwdata[2:0];
        REG_PAD_HEIGHT:    cfg.pad_height    <= pwdata[1:0];
        REG_PAD_WIDTH:     cfg.pad_width     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_index)
      REG_IMAGE_HEIGHT:  prdata = {26'd0, cfg.image_height};
      REG_IMAGE_WIDTH:   prdata = {26'd0, cfg.image_width};
      REG_CHANNEL_COUNT: prdata = {27'd0, cfg.channel_count};
      REG_KERNEL_HEIGHT: prdata = {29'd0, cfg.kernel_height};
      REG_KERNEL_WIDTH:  prdata = {29'd0, cfg.kernel_width};
      REG_PAD_HEIGHT:    prdata = {30'd0, cfg.pad_height};
      REG_PAD_WIDTH:     prdata = {30'd0, cfg.pad_width};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/im2col_ctrl.sv =====
`default_nettype none

`include "im2col_patch_extractor_unit_assert.svh"

module im2col_ctrl
  import im2col_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    busy          = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load      = 1'b1;
          cmd.col_clear = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        // Store an in-range pixel, or start streaming an in-range row
        cmd.wr_en = status.is_write && status.write_ok;
        if (!status.is_write && status.emit_ok) begin
          state_next = ST_RUN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        cmd.rd_en = 1'b1;
        if (status.col_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `IM2COL_ASSERT_NEXT(a_accept_decodes, start && !busy, state == ST_DECODE,
                      "accepted transaction did not enter decode")
  `IM2COL_ASSERT_NOW(a_run_reads_only, state == ST_RUN, cmd.rd_en && !cmd.wr_en,
                     "store written while streaming a row")
  `IM2COL_ASSERT_NEXT(a_last_ends_run, state == ST_RUN && status.col_last,
                      state == ST_IDLE && !busy, "row did not end after its last column")

endmodule

`default_nettype wire

// ===== rtl/core/im2col_dp.sv =====
`default_nettype none

module im2col_dp
  import im2col_pkg::*;
#(
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_HEIGHT   = 32,
  parameter int MAX_WIDTH    = 32,
  parameter int MAX_KERNEL   = 7,
  parameter int MAX_PAD      = 3
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire item_t     item,
  input  wire cfg_t      cfg,
  input  wire ctrl_cmd_t cmd,
  output dp_status_t     status,
  output logic           result_valid,
  output result_t        result
);

  localparam int DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW1   = AW + 1;

  // Caps of each register, limited to what its width can hold
  localparam logic [5:0] H_CAP  = (MAX_HEIGHT > 63)   ? 6'd63 : 6'(MAX_HEIGHT);
  localparam logic [5:0] W_CAP  = (MAX_WIDTH > 63)    ? 6'd63 : 6'(MAX_WIDTH);
  localparam logic [4:0] NC_CAP = (MAX_CHANNELS > 31) ? 5'd31 : 5'(MAX_CHANNELS);
  localparam logic [2:0] K_CAP  = (MAX_KERNEL > 7)    ? 3'd7  : 3'(MAX_KERNEL);
  localparam logic [1:0] P_CAP  = (MAX_PAD > 3)       ? 2'd3  : 2'(MAX_PAD);

  item_t            cur;
  logic [7:0]       col;
  logic [5:0]       h;
  logic [5:0]       w;
  logic [4:0]       nc;
  logic [2:0]       kh_sat;
  logic [2:0]       kw_sat;
  logic [2:0]       kh;
  logic [2:0]       kw;
  logic [1:0]       ph;
  logic [1:0]       pw;
  logic signed [8:0] oh;
  logic signed [8:0] ow;
  logic signed [8:0] srow;
  logic signed [8:0] scol;
  logic             pos_in;
  logic [AW1-1:0]   wr_addr;
  logic [AW1-1:0]   rd_addr;
  logic [AW-1:0]    ram_addr;
  logic [31:0]      rdata;
  logic             s1_valid;
  logic             s1_in;
  logic [5:0]       s1_col;
  logic             s1_last;

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
  end

  // Column counter
  always_ff @(posedge clk) begin
    if (cmd.col_clear) begin
      col <= 8'd0;
    end else if (cmd.rd_en) begin
      col <= col + 8'd1;
    end
  end

  // Saturate the configuration
  always_comb begin
    h      = (cfg.image_height > H_CAP) ? H_CAP : cfg.image_height;
    w      = (cfg.image_width > W_CAP) ? W_CAP : cfg.image_width;
    nc     = (cfg.channel_count > NC_CAP) ? NC_CAP : cfg.channel_count;
    kh_sat = (cfg.kernel_height > K_CAP) ? K_CAP : cfg.kernel_height;
    kw_sat = (cfg.kernel_width > K_CAP) ? K_CAP : cfg.kernel_width;
    kh     = (kh_sat == 3'd0) ? 3'd1 : kh_sat;
    kw     = (kw_sat == 3'd0) ? 3'd1 : kw_sat;
    ph     = (cfg.pad_height > P_CAP) ? P_CAP : cfg.pad_height;
    pw     = (cfg.pad_width > P_CAP) ? P_CAP : cfg.pad_width;
  end

  // Output plane size and source position
  always_comb begin
    oh   = $signed({3'd0, h}) + $signed({6'd0, ph, 1'b0}) - $signed({6'd0, kh}) + 9'sd1;
    ow   = $signed({3'd0, w}) + $signed({6'd0, pw, 1'b0}) - $signed({6'd0, kw}) + 9'sd1;
    srow = $signed({3'd0, cur.out_row}) - $signed({7'd0, ph})
         + $signed({6'd0, cur.kernel_row});
    scol = $signed({1'b0, col}) - $signed({7'd0, pw}) + $signed({6'd0, cur.kernel_col});
    pos_in = !srow[8] && (srow < $signed({3'd0, h}))
          && !scol[8] && (scol < $signed({3'd0, w}));
  end

  // Range checks for the controller
  always_comb begin
    status.is_write = (cur.op == OP_WRITE);
    status.write_ok = ({1'b0, cur.channel} < nc) && ({1'b0, cur.pixel_row} < h)
                   && ({1'b0, cur.pixel_col} < w);
    status.emit_ok  = ({1'b0, cur.channel} < nc) && (cur.kernel_row < kh)
                   && (cur.kernel_col < kw) && (oh > 9'sd0) && (ow > 9'sd0)
                   && ($signed({3'd0, cur.out_row}) < oh);
    status.col_last = ($signed({1'b0, col}) == (ow - 9'sd1));
  end

  // Store addresses at the maximum sizes
  always_comb begin
    wr_addr = (AW1'(cur.channel) * AW1'(MAX_HEIGHT) + AW1'(cur.pixel_row))
            * AW1'(MAX_WIDTH) + AW1'(cur.pixel_col);
    rd_addr = (AW1'(cur.channel) * AW1'(MAX_HEIGHT) + AW1'(srow[7:0]))
            * AW1'(MAX_WIDTH) + AW1'(scol[7:0]);
    ram_addr = cmd.wr_en ? wr_addr[AW-1:0] : rd_addr[AW-1:0];
  end

  im2col_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (cmd.wr_en | cmd.rd_en),
    .we    (cmd.wr_en),
    .addr  (ram_addr),
    .wdata (cur.pixel_value),
    .rdata (rdata)
  );

  // Strobes of the read and output stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= cmd.rd_en;
      result_valid <= s1_valid;
    end
  end

  // Tag travels alongside the store read; drop the data in the padding
  always_ff @(posedge clk) begin
    s1_in          <= pos_in;
    s1_col         <= col[5:0];
    s1_last        <= status.col_last;
    result.value   <= s1_in ? rdata : 32'd0;
    result.out_col <= s1_col;
    result.last    <= s1_last;
  end

endmodule

`default_nettype wire

// ===== rtl/core/im2col_patch_extractor_unit.sv =====
`default_nettype none

// im2col patch extractor, zero padding, stride 1.
// Input: a transaction is taken at a clock edge with start high and busy low.
//   op write stores pixel_value at (channel, pixel_row, pixel_col) when that
//   position lies inside the configured image; otherwise it is dropped.
//   op emit streams output row out_row of the im2col matrix for the given
//   channel and kernel offset, one value per output column, zero in padding.
// Output: each result is on result for one cycle with result_valid high;
//   result.last marks the final column. The receiver cannot stall the block.
// Sequence: a write is busy in the decode state after acceptance. An emit of
//   OW columns is busy in decode, then in run with one store read per cycle
//   from the single-port image store; results pass the store read register and
//   the output register and leave back to back. Out-of-range items give no
//   result and free the block after decode; a new item waits for idle.
// Configuration: APB port, register i at byte address 4*i, pready tied high.
//   Write registers only while no row is being streamed.
// Reset: synchronous; registers take their defaults, the image store keeps
//   no defined contents until written.
module im2col_patch_extractor_unit
  import im2col_pkg::*;
#(
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_HEIGHT   = 32,
  parameter int MAX_WIDTH    = 32,
  parameter int MAX_KERNEL   = 7,
  parameter int MAX_PAD      = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output logic             result_valid,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  im2col_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  im2col_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  im2col_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_KERNEL   (MAX_KERNEL),
    .MAX_PAD      (MAX_PAD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== sim/im2col_row_checker.sv =====
`timescale 1ns / 1ps

// Effective image and kernel sizes, shared by the checker and the stimulus.
package im2col_dims_pkg;
  import im2col_pkg::*;

  localparam int LIMIT_CHANNELS = 16;
  localparam int LIMIT_HEIGHT   = 32;
  localparam int LIMIT_WIDTH    = 32;
  localparam int LIMIT_KERNEL   = 7;
  localparam int LIMIT_PAD      = 3;
  localparam int STORE_WORDS    = LIMIT_CHANNELS * LIMIT_HEIGHT * LIMIT_WIDTH;

  typedef struct packed {
    int h;
    int w;
    int nc;
    int kh;
    int kw;
    int ph;
    int pw;
    int oh;
    int ow;
  } dims_t;

  function automatic int cap(input int v, input int hi);
    return (v > hi) ? hi : v;
  endfunction

  // Saturate every register to its limit; a zero kernel size acts as one
  function automatic dims_t dims_of(input cfg_t c);
    dims_t d;
    d.h  = cap(int'(c.image_height), LIMIT_HEIGHT);
    d.w  = cap(int'(c.image_width), LIMIT_WIDTH);
    d.nc = cap(int'(c.channel_count), LIMIT_CHANNELS);
    d.kh = cap(int'(c.kernel_height), LIMIT_KERNEL);
    d.kw = cap(int'(c.kernel_width), LIMIT_KERNEL);
    d.ph = cap(int'(c.pad_height), LIMIT_PAD);
    d.pw = cap(int'(c.pad_width), LIMIT_PAD);
    if (d.kh < 1) d.kh = 1;
    if (d.kw < 1) d.kw = 1;
    d.oh = d.h + 2 * d.ph - d.kh + 1;
    d.ow = d.w + 2 * d.pw - d.kw + 1;
    return d;
  endfunction

endpackage

module im2col_row_checker
  import im2col_pkg::*;
  import im2col_dims_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  item_t       item,
  input  logic        result_valid,
  input  result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          columns_outstanding,
  output int          columns_seen
);

  cfg_t        shadow_cfg;
  logic [31:0] image_copy [STORE_WORDS];
  result_t     columns_due [$];
  result_t     oldest;

  // Store a write, or queue every column value an emit should stream
  task automatic derive_columns(input item_t it);
    dims_t       d;
    int          src_row;
    int          src_col;
    result_t     col_val;
    d = dims_of(shadow_cfg);
    if (it.op == OP_WRITE) begin
      if (int'(it.channel) < d.nc && int'(it.pixel_row) < d.h && int'(it.pixel_col) < d.w)
        image_copy[{it.channel, it.pixel_row, it.pixel_col}] = it.pixel_value;
    end else if (int'(it.channel) < d.nc && int'(it.kernel_row) < d.kh &&
                 int'(it.kernel_col) < d.kw && d.oh > 0 && d.ow > 0 &&
                 int'(it.out_row) < d.oh) begin
      src_row = int'(it.out_row) - d.ph + int'(it.kernel_row);
      for (int j = 0; j < d.ow; j++) begin
        src_col = j - d.pw + int'(it.kernel_col);
        col_val.value = '0;
        // padding positions read as zero
        if (src_row >= 0 && src_row < d.h && src_col >= 0 && src_col < d.w)
          col_val.value = image_copy[{it.channel, src_row[4:0], src_col[4:0]}];
        col_val.out_col = 6'(j);
        col_val.last    = (j == d.ow - 1);
        columns_due.push_back(col_val);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg = CFG_RESET;
      columns_due.delete();
      mismatch_count = 0;
      columns_seen = 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_IMAGE_HEIGHT:  shadow_cfg.image_height  = pwdata[5:0];
          REG_IMAGE_WIDTH:   shadow_cfg.image_width   = pwdata[5:0];
          REG_CHANNEL_COUNT: shadow_cfg.channel_count = pwdata[4:0];
          REG_KERNEL_HEIGHT: shadow_cfg.kernel_height = pwdata[2:0];
          REG_KERNEL_WIDTH:  shadow_cfg.kernel_width  = pwdata[2:0];
          REG_PAD_HEIGHT:    shadow_cfg.pad_height    = pwdata[1:0];
          REG_PAD_WIDTH:     shadow_cfg.pad_width     = pwdata[1:0];
          default: ;
        endcase
      end
      // compare each streamed column against the oldest one due
      if (result_valid) begin
        columns_seen++;
        if (columns_due.size() == 0) begin
          $display("%0t: unexpected column: value %h col %0d last %b", $time,
                   result.value, result.out_col, result.last);
          mismatch_count++;
        end else begin
          oldest = columns_due.pop_front();
          if (result !== oldest) begin
            $display("%0t: expected value %h col %0d last %b, got value %h col %0d last %b",
                     $time, oldest.value, oldest.out_col, oldest.last,
                     result.value, result.out_col, result.last);
            mismatch_count++;
          end
        end
      end
      // accept a transaction
      if (start && !busy)
        derive_columns(item);
    end
    columns_outstanding = columns_due.size();
  end

endmodule

// ===== sim/tb_im2col_patch_extractor_unit.sv =====
`timescale 1ns / 1ps

module tb_im2col_patch_extractor_unit;
  import im2col_pkg::*;
  import im2col_dims_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        result_valid;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int columns_outstanding;
  int columns_seen;

  // Stimulus bookkeeping: current registers and which pixels hold a value
  cfg_t current_cfg = CFG_RESET;
  bit   pixel_known [STORE_WORDS];
  int   burst_left = 0;
  bit   steady = 1'b0;
  int   items_sent = 0;
  int   fill_writes = 0;
  int   settings_used = 1;

  always #6 clk = ~clk;

  im2col_patch_extractor_unit i_dut (.*);

  im2col_row_checker i_checker (.*);

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t write_item(input int ch, input int row, input int col,
                                       input logic [31:0] pix);
    item_t it;
    it = random_item();
    it.op          = OP_WRITE;
    it.channel     = ch[3:0];
    it.pixel_row   = row[4:0];
    it.pixel_col   = col[4:0];
    it.pixel_value = pix;
    return it;
  endfunction

  function automatic item_t emit_item(input int ch, input int kr, input int kc, input int orow);
    item_t it;
    it = random_item();
    it.op         = OP_EMIT;
    it.channel    = ch[3:0];
    it.kernel_row = kr[2:0];
    it.kernel_col = kc[2:0];
    it.out_row    = orow[5:0];
    return it;
  endfunction

  function automatic int pick_below(input int n);
    return (n > 0) ? int'($urandom_range(0, n - 1)) : int'($urandom);
  endfunction

  // Mostly small images, now and then oversized registers and zero sizes
  function automatic cfg_t random_setting();
    cfg_t c;
    c.image_height  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(9, 63))
                                                  : 6'($urandom_range(0, 8));
    c.image_width   = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(9, 63))
                                                  : 6'($urandom_range(0, 8));
    c.channel_count = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4));
    c.kernel_height = 3'($urandom);
    c.kernel_width  = 3'($urandom);
    c.pad_height    = 2'($urandom);
    c.pad_width     = 2'($urandom);
    return c;
  endfunction

  // Drop start, then wait until every column has arrived and the block is free
  task automatic drain();
    int waited;
    start <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while ((columns_outstanding != 0 || busy) && waited < 4000);
    repeat (6) @(negedge clk);
  endtask

  // Setup and access phase; unused upper data bits carry noise
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] field, input int width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom << width) | field;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(input cfg_t c);
    drain();
    write_reg(REG_IMAGE_HEIGHT, 32'(c.image_height), 6);
    write_reg(REG_IMAGE_WIDTH, 32'(c.image_width), 6);
    write_reg(REG_CHANNEL_COUNT, 32'(c.channel_count), 5);
    write_reg(REG_KERNEL_HEIGHT, 32'(c.kernel_height), 3);
    write_reg(REG_KERNEL_WIDTH, 32'(c.kernel_width), 3);
    write_reg(REG_PAD_HEIGHT, 32'(c.pad_height), 2);
    write_reg(REG_PAD_WIDTH, 32'(c.pad_width), 2);
    psel    <= 1'b0;
    penable <= 1'b0;
    current_cfg = c;
    settings_used++;
    steady = ($urandom_range(0, 2) == 0);
  endtask

  // Present one transaction, idling between bursts, and hold it until taken
  task automatic send_raw(input item_t it);
    dims_t d;
    int    gap;
    d = dims_of(current_cfg);
    if (burst_left == 0) begin
      if (steady)
        gap = 0;
      else if ($urandom_range(0, 3) == 0)
        gap = $urandom_range(10, 45);
      else
        gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (it.op == OP_WRITE && int'(it.channel) < d.nc && int'(it.pixel_row) < d.h &&
        int'(it.pixel_col) < d.w)
      pixel_known[{it.channel, it.pixel_row, it.pixel_col}] = 1'b1;
  endtask

  // An emit reads one source row: give every pixel of it a value first
  task automatic send_item(input item_t it);
    dims_t d;
    int    src_row;
    d = dims_of(current_cfg);
    src_row = int'(it.out_row) - d.ph + int'(it.kernel_row);
    if (it.op == OP_EMIT && int'(it.channel) < d.nc && src_row >= 0 && src_row < d.h) begin
      for (int c = 0; c < d.w; c++) begin
        if (!pixel_known[{it.channel, src_row[4:0], 5'(c)}]) begin
          send_raw(write_item(int'(it.channel), src_row, c, $urandom));
          fill_writes++;
        end
      end
    end
    send_raw(it);
  endtask

  // Random mix: in-range writes, well-formed emits and raw noise
  task automatic random_items(input int count);
    dims_t d;
    int    pick;
    d = dims_of(current_cfg);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_item(write_item(pick_below(d.nc), pick_below(d.h), pick_below(d.w), $urandom));
      else if (pick < 85)
        send_item(emit_item(pick_below(d.nc), pick_below(d.kh), pick_below(d.kw),
                            pick_below(d.oh)));
      else
        send_item(random_item());
    end
  endtask

  initial begin
    cfg_t  c;
    dims_t d;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset registers: corner pixels, padding rows and rejected transactions
    send_item(write_item(0, 0, 0, 32'hFFFF_FFFF));
    send_item(write_item(0, 31, 31, 32'h0000_0000));
    send_item(write_item(1, 0, 0, 32'h1234_5678));
    send_item(emit_item(0, 0, 0, 0));
    send_item(emit_item(0, 2, 2, 31));
    send_item(emit_item(1, 1, 1, 5));
    send_item(emit_item(0, 3, 0, 5));
    send_item(emit_item(0, 0, 7, 5));
    send_item(emit_item(0, 1, 1, 32));
    send_item(emit_item(0, 1, 0, 0));
    send_item(emit_item(0, 2, 2, 30));

    // Oversized registers and zero kernel: widest output row
    apply_setting('{image_height: 6'd63, image_width: 6'd40, channel_count: 5'd31,
                    kernel_height: 3'd0, kernel_width: 3'd0, pad_height: 2'd3,
                    pad_width: 2'd3});
    send_item(emit_item(15, 0, 0, 37));
    send_item(emit_item(15, 0, 0, 3));
    random_items(10);

    // Single pixel image under the largest kernel and padding
    apply_setting('{image_height: 6'd1, image_width: 6'd1, channel_count: 5'd16,
                    kernel_height: 3'd7, kernel_width: 3'd7, pad_height: 2'd3,
                    pad_width: 2'd3});
    random_items(20);

    // Zero height image: every value is padding
    apply_setting('{image_height: 6'd0, image_width: 6'd5, channel_count: 5'd2,
                    kernel_height: 3'd2, kernel_width: 3'd3, pad_height: 2'd1,
                    pad_width: 2'd2});
    random_items(15);

    // Kernel taller than the padded image: no output at all
    apply_setting('{image_height: 6'd1, image_width: 6'd2, channel_count: 5'd1,
                    kernel_height: 3'd7, kernel_width: 3'd1, pad_height: 2'd0,
                    pad_width: 2'd0});
    random_items(10);

    repeat (8) begin
      c = random_setting();
      apply_setting(c);
      d = dims_of(c);
      random_items((d.h > 8 || d.w > 8) ? 8 : 20);
    end

    drain();
    if (columns_outstanding != 0)
      $display("%0t: %0d expected columns never arrived", $time, columns_outstanding);
    $display("Run covered %0d transactions (%0d of them pre-fill writes) over %0d register",
             items_sent, fill_writes, settings_used);
    $display("settings, and %0d streamed columns were compared.", columns_seen);
    if (mismatch_count == 0 && columns_outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
